// File: rtl/bitmap_page_allocator_macros.svh
// Assertion macros for the bitmap page allocator checker.
// Depends on nothing; the including module must have clk and arst_n.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// Used by the top level and by its port checker; depends on nothing.
package bpa_pkg;

	localparam int WORD_BITS  = 64;
	localparam int PAGE_W     = 12;
	localparam int PAGE_WORDS = (1 << PAGE_W) / WORD_BITS;
	localparam int FIRST_W    = 6;
	localparam int COUNT_W    = 7;
	localparam int BIT_W      = 6;
	localparam int PTR_W      = 7;
	localparam int END_W      = 8;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

	typedef enum logic [1:0] {
		OP_ALLOC_AREA  = 2'd0,
		OP_ALLOC_AVAIL = 2'd1,
		OP_CLAIM       = 2'd2,
		OP_FREE        = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_NOFREE = 2'd1,
		STATUS_TAKEN  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_AREA0_FIRST = 3'd0,
		REG_AREA0_WORDS = 3'd1,
		REG_AREA1_FIRST = 3'd2,
		REG_AREA1_WORDS = 3'd3,
		REG_AREA2_FIRST = 3'd4,
		REG_AREA2_WORDS = 3'd5,
		REG_AREA3_FIRST = 3'd6,
		REG_AREA3_WORDS = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ALLOC_WR,
		ST_MODIFY,
		ST_DONE
	} state_t;

	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: rtl/bitmap_page_allocator.sv
// Claim and free read the bitmap word, modify it in ST_MODIFY and pass the result through
// ST_DONE to the output register. Allocation reads one bitmap word per cycle and stops at
// the first word with a free bit, or when the chosen area, or both available areas, are
// full. One item is in work at a time; the next transfer is taken only in ST_IDLE, which
// follows the load of the output register. Reset clears the bitmap at once through one
// valid bit per memory row, and clears all area registers to zero. Depends on bpa_pkg.
module bitmap_page_allocator #(
	parameter int BITMAP_WORDS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// page_index [11:0], zero fill [15:12]
	input  logic [bpa_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// opcode [1:0], area_select [3:2]
	input  logic [bpa_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// result_page [11:0], zero fill [15:12]
	output logic [bpa_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status [1:0]
	output logic [bpa_pkg::M_TUSER_W-1:0] m_axis_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpa_pkg::APB_AW-1:0]    paddr,
	input  logic [bpa_pkg::APB_DW-1:0]    pwdata,
	output logic [bpa_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import bpa_pkg::*;

	localparam int MEM_DEPTH = (BITMAP_WORDS < PAGE_WORDS) ? BITMAP_WORDS : PAGE_WORDS;
	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LIMIT = PTR_W'(MEM_DEPTH);

	logic [WORD_BITS-1:0] mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;

	logic [FIRST_W-1:0] first_q [4];
	logic [COUNT_W-1:0] count_q [4];

	state_t               state_q, state_d;
	opcode_t              op_q;
	logic                 second_q;
	logic [PTR_W-1:0]     ptr_q;
	logic [END_W-1:0]     end_q;
	logic [PAGE_W-1:0]    pg_q;
	logic                 pg_ok_q;
	logic                 rd_pend_s1;
	logic [FIRST_W-1:0]   rd_widx_s1;
	logic [WORD_BITS-1:0] mem_rd_s1;
	logic                 vld_rd_s1;
	logic [WORD_BITS-1:0] hit_word_q;
	logic [FIRST_W-1:0]   hit_idx_q;
	logic [PAGE_W-1:0]    res_page_q;
	status_t              res_status_q;
	logic                 out_valid_q;
	logic [PAGE_W-1:0]    out_page_q;
	status_t              out_status_q;

	opcode_t              in_op;
	logic [1:0]           in_sel;
	logic [PAGE_W-1:0]    in_pg;
	logic                 in_pg_ok;
	logic                 accept;
	logic                 cfg_wr;
	reg_idx_t             cfg_idx;

	logic                 rd_en, wr_en;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [WORD_BITS-1:0] rd_data;
	logic                 in_range, hit;
	logic                 scan_start, scan_next_area, scan_step, take_hit;
	logic                 res_load, out_load;
	logic [PAGE_W-1:0]    res_page_d;
	status_t              res_status_d;
	logic [BIT_W-1:0]     alloc_bit, pg_bit;
	logic [1:0]           start_area;

	assign in_op    = opcode_t'(s_axis_tuser[1:0]);
	assign in_sel   = s_axis_tuser[3:2];
	assign in_pg    = s_axis_tdata[PAGE_W-1:0];
	assign in_pg_ok = {1'b0, in_pg[PAGE_W-1:BIT_W]} < LIMIT;
	assign accept   = s_axis_tvalid && s_axis_tready;

	assign rd_data   = vld_rd_s1 ? mem_rd_s1 : '0;
	assign in_range  = ({1'b0, ptr_q} < end_q) && (ptr_q < LIMIT);
	assign hit       = rd_pend_s1 && (rd_data != FULL_WORD);
	assign alloc_bit = first_zero(hit_word_q);
	assign pg_bit    = pg_q[BIT_W-1:0];
	assign start_area = (in_op == OP_ALLOC_AREA) ? in_sel : 2'd0;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_AREA0_FIRST: prdata = APB_DW'(first_q[0]);
			REG_AREA0_WORDS: prdata = APB_DW'(count_q[0]);
			REG_AREA1_FIRST: prdata = APB_DW'(first_q[1]);
			REG_AREA1_WORDS: prdata = APB_DW'(count_q[1]);
			REG_AREA2_FIRST: prdata = APB_DW'(first_q[2]);
			REG_AREA2_WORDS: prdata = APB_DW'(count_q[2]);
			REG_AREA3_FIRST: prdata = APB_DW'(first_q[3]);
			REG_AREA3_WORDS: prdata = APB_DW'(count_q[3]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				first_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			if (!cfg_idx[0]) begin
				first_q[cfg_idx[2:1]] <= pwdata[FIRST_W-1:0];
			end else begin
				count_q[cfg_idx[2:1]] <= pwdata[COUNT_W-1:0];
			end
		end
	end

	// Sequencer.
	always_comb begin
		state_d        = state_q;
		s_axis_tready  = 1'b0;
		rd_en          = 1'b0;
		rd_addr        = ptr_q[AW-1:0];
		wr_en          = 1'b0;
		wr_addr        = hit_idx_q[AW-1:0];
		wr_data        = hit_word_q | (WORD_BITS'(1) << alloc_bit);
		scan_start     = 1'b0;
		scan_next_area = 1'b0;
		scan_step      = 1'b0;
		take_hit       = 1'b0;
		res_load       = 1'b0;
		res_page_d     = '0;
		res_status_d   = STATUS_OK;
		out_load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (in_op == OP_ALLOC_AREA || in_op == OP_ALLOC_AVAIL) begin
						scan_start = 1'b1;
						state_d    = ST_SCAN;
					end else begin
						rd_en   = in_pg_ok;
						rd_addr = in_pg[BIT_W+AW-1:BIT_W];
						state_d = ST_MODIFY;
					end
				end
			end
			ST_SCAN: begin
				priority if (hit) begin
					take_hit = 1'b1;
					state_d  = ST_ALLOC_WR;
				end else if (in_range) begin
					rd_en     = 1'b1;
					scan_step = 1'b1;
				end else if (!rd_pend_s1) begin
					if (op_q == OP_ALLOC_AVAIL && !second_q) begin
						scan_next_area = 1'b1;
					end else begin
						res_load     = 1'b1;
						res_status_d = STATUS_NOFREE;
						state_d      = ST_DONE;
					end
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_ALLOC_WR: begin
				wr_en      = 1'b1;
				res_load   = 1'b1;
				res_page_d = {hit_idx_q, alloc_bit};
				state_d    = ST_DONE;
			end
			ST_MODIFY: begin
				wr_addr  = pg_q[BIT_W+AW-1:BIT_W];
				res_load = 1'b1;
				state_d  = ST_DONE;
				if (op_q == OP_CLAIM) begin
					wr_data = rd_data | (WORD_BITS'(1) << pg_bit);
					if (pg_ok_q && !rd_data[pg_bit]) begin
						wr_en      = 1'b1;
						res_page_d = pg_q;
					end else begin
						res_status_d = STATUS_TAKEN;
					end
				end else begin
					wr_data = rd_data & ~(WORD_BITS'(1) << pg_bit);
					wr_en   = pg_ok_q;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_ALLOC_AREA;
			second_q   <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_en && (state_q == ST_SCAN);
			if (accept) begin
				op_q     <= in_op;
				second_q <= 1'b0;
			end else if (scan_next_area) begin
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pg_q    <= in_pg;
			pg_ok_q <= in_pg_ok;
		end
		if (scan_start) begin
			ptr_q <= {1'b0, first_q[start_area]};
			end_q <= END_W'(first_q[start_area]) + END_W'(count_q[start_area]);
		end else if (scan_next_area) begin
			ptr_q <= {1'b0, first_q[1]};
			end_q <= END_W'(first_q[1]) + END_W'(count_q[1]);
		end else if (scan_step) begin
			ptr_q <= ptr_q + PTR_W'(1);
		end
		if (scan_step) begin
			rd_widx_s1 <= ptr_q[FIRST_W-1:0];
		end
		if (take_hit) begin
			hit_word_q <= rd_data;
			hit_idx_q  <= rd_widx_s1;
		end
		if (res_load) begin
			res_page_q   <= res_page_d;
			res_status_q <= res_status_d;
		end
		if (out_load) begin
			out_page_q   <= res_page_q;
			out_status_q <= res_status_q;
		end
	end

	// Bitmap memory, one row per 64 pages.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_rd_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_s1 <= vld_q[rd_addr];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'(out_page_q);
	assign m_axis_tuser  = out_status_q;

endmodule

// File: rtl/bpa_checker.sv
// Port-level checker for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator_macros.svh.
`include "bitmap_page_allocator_macros.svh"

module bpa_port_asserts (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [bpa_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [bpa_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import bpa_pkg::*;

	logic in_xfer;
	logic out_wait;
	logic out_fail;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_wait = m_axis_tvalid && !m_axis_tready;
	assign out_fail = m_axis_tvalid && (m_axis_tuser != STATUS_OK);

	`BPA_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}), "Stalled result changed.")
	`BPA_ASSERT_SAME(a_fail_zero, out_fail, m_axis_tdata == '0, "Failed transfer carries a page.")
	`BPA_ASSERT_NEXT(a_one_in_work, in_xfer, !s_axis_tready, "Second item taken while busy.")
	`BPA_ASSERT_NEXT(a_no_instant_result, in_xfer, !$rose(m_axis_tvalid), "Result came too early.")

endmodule

bind bitmap_page_allocator bpa_port_asserts u_bpa_port_asserts (.*);
